// File: rtl/core/wwss_pkg.sv
`default_nettype none
package wwss_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 16;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 16;
  localparam int LEN_W     = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW   = 3'd0,
    CFG_PATTERN_HIGH  = 3'd1,
    CFG_PATTERN_LEN   = 3'd2,
    CFG_SEP_MASK_LOW  = 3'd3,
    CFG_SEP_MASK_HIGH = 3'd4,
    CFG_IGNORE_CASE   = 3'd5
  } cfg_reg_t;

  // default separators: space , - <tab> . ? ! + : ; < > # and _
  localparam logic [CFG_W-1:0] SEP_MASK_LOW_RST  = 64'hDC00_780B_0000_0200;
  localparam logic [CFG_W-1:0] SEP_MASK_HIGH_RST = 64'h0000_0000_8000_0000;
  localparam logic [LEN_W-1:0] PATTERN_LEN_RST   = 5'd1;

endpackage
`default_nettype wire

// File: rtl/core/wwss_if.sv
`default_nettype none
interface wwss_in_if
  import wwss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last;

  modport source (output valid, output text_byte, output last, input ready);
  modport sink   (input valid, input text_byte, input last, output ready);
endinterface

interface wwss_out_if
  import wwss_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface
`default_nettype wire

// File: rtl/core/whole_word_stream_search_top.sv
// An accepted text byte waits in the input register and its result beat in the output register.
// Throughput: one text byte per cycle unless the output stalls; the input and output registers
//   each hold one beat, and a byte is taken while a result waits only if the input one is empty.
// Reset (synchronous, rst_n low): search state and both pipeline registers clear, and the
//   configuration registers return to their defaults (pattern length 1, default separators).
`default_nettype none
module whole_word_stream_search_top
  import wwss_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  wwss_in_if.sink              in_chan,
  wwss_out_if.source           out_chan,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [CFG_W-1:0] pat_low_r;
  logic [CFG_W-1:0] pat_high_r;
  logic [LEN_W-1:0] pat_len_r;
  logic [CFG_W-1:0] sep_low_r;
  logic [CFG_W-1:0] sep_high_r;
  logic             ign_case_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= PATTERN_LEN_RST;
      sep_low_r  <= SEP_MASK_LOW_RST;
      sep_high_r <= SEP_MASK_HIGH_RST;
      ign_case_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_LOW:   pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH:  pat_high_r <= cfg_wdata;
        CFG_PATTERN_LEN:   pat_len_r  <= cfg_wdata[LEN_W-1:0];
        CFG_SEP_MASK_LOW:  sep_low_r  <= cfg_wdata;
        CFG_SEP_MASK_HIGH: sep_high_r <= cfg_wdata;
        CFG_IGNORE_CASE:   ign_case_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b, input logic ic);
    logic [BYTE_W-1:0] r;
    r = b;
    if (ic && b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
    return r;
  endfunction

  // input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              s1_fire;

  // output register
  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_pos_r;

  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && s1_adv;
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.text_byte;
      s1_last_r <= in_chan.last;
    end
  end

  // search state
  logic [LEN_W-1:0]       pidx_r, pidx_nxt;
  logic                   matching_r, matching_nxt;
  logic                   aftsep_r, aftsep_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic                   reported_r, reported_nxt;

  logic [BYTE_W-1:0]      c;
  logic                   c_sep;
  logic [LEN_W-1:0]       len;
  logic [BYTE_W-1:0]      pat_byte;
  logic [2*CFG_W-1:0]     pat_word;
  logic [2*CFG_W-1:0]     sep_word;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;
  logic                   res_valid;
  logic                   res_found;
  logic [POS_W-1:0]       res_pos;

  assign pat_word = {pat_high_r, pat_low_r};
  assign sep_word = {sep_high_r, sep_low_r};

  always_comb begin
    c        = fold(s1_byte_r, ign_case_r);
    c_sep    = !c[7] && sep_word[c[6:0]];
    if (pat_len_r == '0)                        len = LEN_W'(1);
    else if (pat_len_r > LEN_W'(PATTERN_MAX))   len = LEN_W'(PATTERN_MAX);
    else                                        len = pat_len_r;
    pat_byte = fold(pat_word[{pidx_r[3:0], 3'b000} +: BYTE_W], ign_case_r);

    pidx_nxt     = pidx_r;
    matching_nxt = matching_r;
    aftsep_nxt   = aftsep_r;
    reported_nxt = reported_r;
    offset_nxt   = offset_r + OFFSET_BITS'(1);
    hit          = 1'b0;
    start        = '0;

    if (!reported_r) begin
      if (matching_r) begin
        if (pidx_r >= len) begin
          if (c_sep) begin
            hit   = 1'b1;
            start = offset_r - OFFSET_BITS'(len);
          end else begin
            matching_nxt = 1'b0;
            aftsep_nxt   = 1'b0;
            pidx_nxt     = '0;
          end
        end else if (c == pat_byte) begin
          pidx_nxt = pidx_r + LEN_W'(1);
        end else begin
          matching_nxt = 1'b0;
          pidx_nxt     = '0;
          aftsep_nxt   = c_sep;
        end
      end else if (!aftsep_r) begin
        if (c_sep) aftsep_nxt = 1'b1;
        pidx_nxt = '0;
      end else if (c == pat_byte) begin
        // pattern index is zero here, so pat_byte is pattern byte 0
        matching_nxt = 1'b1;
        pidx_nxt     = LEN_W'(1);
      end else begin
        aftsep_nxt = c_sep;
        pidx_nxt   = '0;
      end

      if (!hit && s1_last_r && matching_nxt && pidx_nxt >= len) begin
        hit   = 1'b1;
        start = offset_r + OFFSET_BITS'(1) - OFFSET_BITS'(len);
      end
    end

    res_valid = hit || (s1_last_r && !reported_r);
    res_found = hit;
    res_pos   = hit ? POS_W'(start) : '0;

    if (hit && !s1_last_r) reported_nxt = 1'b1;

    // end of text: back to the reset search state
    if (s1_last_r) begin
      pidx_nxt     = '0;
      matching_nxt = 1'b0;
      aftsep_nxt   = 1'b1;
      offset_nxt   = '0;
      reported_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r     <= '0;
      matching_r <= 1'b0;
      aftsep_r   <= 1'b1;
      offset_r   <= '0;
      reported_r <= 1'b0;
    end else if (s1_fire) begin
      pidx_r     <= pidx_nxt;
      matching_r <= matching_nxt;
      aftsep_r   <= aftsep_nxt;
      offset_r   <= offset_nxt;
      reported_r <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_found_r <= res_found;
      out_pos_r   <= res_pos;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.found    = out_found_r;
  assign out_chan.position = out_pos_r;

  a_pidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    pidx_r <= LEN_W'(PATTERN_MAX))
    else $error("pattern index beyond pattern size");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !matching_r |-> pidx_r == '0)
    else $error("pattern index nonzero outside a candidate");

  a_notfound_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_pos_r == '0)
    else $error("not-found beat carries a position");

  a_one_per_text: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && reported_r && !s1_last_r |-> !res_valid)
    else $error("second result within one text");

endmodule
`default_nettype wire
